/* hdl/cpcr_pkg.sv */
package cpcr_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  // Radius, radius sum and the squares that follow from them
  localparam int RAD_W = 16;
  localparam int RS_W  = RAD_W + 1;
  localparam int SQ_W  = 2 * RS_W;
  localparam int D2_W  = SQ_W + 1;
  localparam int MIN2_W = 2 * RAD_W;

  // Distance root: sqrt(d2 * 2^16), Q.8
  localparam int SQRT_SHIFT = 16;
  localparam int RADICAND_W = SQ_W + SQRT_SHIFT;
  localparam int ROOT_W     = RADICAND_W / 2;
  localparam int REM_W      = ROOT_W + 3;

  // Push and direction scaling
  localparam int KF_W      = 16;
  localparam int FRAC_SH   = 16;
  localparam int PUSH_W    = ROOT_W;
  localparam int PROD_W    = PUSH_W + KF_W;
  localparam int Q_W       = RS_W;
  localparam int DIVISOR_W = ROOT_W + 1;
  localparam int NUM_W     = DIVISOR_W + Q_W - 1;

  localparam int SAT_W = 34;

  localparam logic [KF_W-1:0]  KEEP_FRACTION_RST = 16'd39322;
  localparam logic [RAD_W-1:0] MIN_DISTANCE_RST  = 16'd256;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FRACTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 1'b1;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_FIRST_FIXED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND_FIXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHARED       = 2'd2;

  typedef struct packed {
    logic              contact;
    logic [MODE_W-1:0] mode;
    logic              sx;
    logic              sy;
    logic [RS_W-1:0]   rs;
    logic [RS_W-1:0]   ax;
    logic [RS_W-1:0]   ay;
  } side_t;

endpackage

/* hdl/cpcr_sqrt.sv */
module cpcr_sqrt
  import cpcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [RADICAND_W-1:0] radicand,
  output logic [ROOT_W-1:0]     root
);

  // One result bit per stage, restoring digit recurrence
  logic [REM_W-1:0]      rem_r   [ROOT_W];
  logic [ROOT_W-1:0]     root_r  [ROOT_W];
  logic [RADICAND_W-1:0] x_r     [ROOT_W];
  logic [REM_W-1:0]      rem_nxt [ROOT_W];
  logic [ROOT_W-1:0]     root_nxt[ROOT_W];
  logic [RADICAND_W-1:0] x_nxt   [ROOT_W];

  always_comb begin
    logic [REM_W-1:0]      rin;
    logic [ROOT_W-1:0]     qin;
    logic [RADICAND_W-1:0] xin;
    logic [REM_W-1:0]      sh;
    logic [REM_W-1:0]      tr;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rin = '0;
        qin = '0;
        xin = radicand;
      end else begin
        rin = rem_r[k-1];
        qin = root_r[k-1];
        xin = x_r[k-1];
      end
      sh = {rin[REM_W-3:0], xin[RADICAND_W-1 -: 2]};
      tr = {1'b0, qin, 2'b01};
      if (sh >= tr) begin
        rem_nxt[k]  = sh - tr;
        root_nxt[k] = {qin[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = sh;
        root_nxt[k] = {qin[ROOT_W-2:0], 1'b0};
      end
      x_nxt[k] = {xin[RADICAND_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        x_r[k]    <= x_nxt[k];
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

/* hdl/cpcr_div.sv */
module cpcr_div
  import cpcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_W-1:0]     num,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [Q_W-1:0]       quot
);

  // One quotient bit per stage, most significant first
  logic [NUM_W-1:0]     rem_r   [Q_W];
  logic [DIVISOR_W-1:0] den_r   [Q_W];
  logic [Q_W-1:0]       q_r     [Q_W];
  logic [NUM_W-1:0]     rem_nxt [Q_W];
  logic [Q_W-1:0]       q_nxt   [Q_W];
  logic [DIVISOR_W-1:0] den_nxt [Q_W];

  always_comb begin
    logic [NUM_W-1:0]     rin;
    logic [DIVISOR_W-1:0] din;
    logic [Q_W-1:0]       qin;
    logic [NUM_W-1:0]     tr;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        rin = num;
        din = divisor;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        din = den_r[k-1];
        qin = q_r[k-1];
      end
      tr = NUM_W'(din) << (Q_W - 1 - k);
      if (rin >= tr) begin
        rem_nxt[k] = rin - tr;
        q_nxt[k]   = {qin[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rin;
        q_nxt[k]   = {qin[Q_W-2:0], 1'b0};
      end
      den_nxt[k] = din;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign quot = q_r[Q_W-1];

endmodule

/* hdl/circle_pair_collision_resolve_core.sv */
// Channel   Direction  Handshake             Beat
// in_       input      in_valid / in_stall   two circles: centre, radius, fixed flag
// out_      output     out_valid / out_stall contact flag and both displacements
// cfg_      input      cfg_we                keep_fraction, min_distance write
//
// One beat enters per cycle while the output is not stalled. The pipe has 49 register
// stages: three front stages, 25 square-root steps, three scaling stages, 17 divider
// steps, output register. The root and divider iterations set the depth.
// Reset (rst_n low, synchronous) empties the pipe and loads the register defaults.
// A stall on a valid output beat holds the whole pipe; in_stall rises in the same cycle.
module circle_pair_collision_resolve_core
  import cpcr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic [RAD_W-1:0]              in_first_radius,
  input  logic                          in_first_fixed,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic [RAD_W-1:0]              in_second_radius,
  input  logic                          in_second_fixed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_contact,
  output logic signed [COORD_WIDTH-1:0] out_first_dx,
  output logic signed [COORD_WIDTH-1:0] out_first_dy,
  output logic signed [COORD_WIDTH-1:0] out_second_dx,
  output logic signed [COORD_WIDTH-1:0] out_second_dy
);

  localparam int DW = COORD_WIDTH + 1;
  localparam logic signed [SAT_W-1:0] SAT_HI =
    SAT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W;

  // Global advance: the whole pipe moves unless the output beat is held.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Configuration registers
  logic [KF_W-1:0]  keep_fraction_r;
  logic [RAD_W-1:0] min_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_fraction_r <= KEEP_FRACTION_RST;
      min_distance_r  <= MIN_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEP_FRACTION: keep_fraction_r <= cfg_wdata;
        CFG_MIN_DISTANCE:  min_distance_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: center differences, magnitudes, radius sum, motion mode
  logic signed [DW-1:0] dx_s1, dy_s1;
  logic [DW-1:0]        ax_s1, ay_s1;
  logic [MODE_W-1:0]    mode_s1;

  always_comb begin
    dx_s1 = DW'(in_second_x) - DW'(in_first_x);
    dy_s1 = DW'(in_second_y) - DW'(in_first_y);
    ax_s1 = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
    ay_s1 = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
    if (in_first_fixed) begin
      mode_s1 = MODE_FIRST_FIXED;
    end else if (in_second_fixed) begin
      mode_s1 = MODE_SECOND_FIXED;
    end else begin
      mode_s1 = MODE_SHARED;
    end
  end

  logic              v1_r;
  logic [DW-1:0]     ax1_r, ay1_r;
  logic              sx1_r, sy1_r;
  logic [RS_W-1:0]   rs1_r;
  logic [MODE_W-1:0] mode1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r   <= ax_s1;
      ay1_r   <= ay_s1;
      sx1_r   <= dx_s1[DW-1];
      sy1_r   <= dy_s1[DW-1];
      rs1_r   <= RS_W'(in_first_radius) + RS_W'(in_second_radius);
      mode1_r <= mode_s1;
    end
  end

  // Stage 2: bounding-box test and squares
  logic              v2_r, near2_r;
  logic [SQ_W-1:0]   sqx2_r, sqy2_r, rs_sq2_r;
  logic [MIN2_W-1:0] min_sq2_r;
  side_t             side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near2_r   <= (ax1_r < DW'(rs1_r)) && (ay1_r < DW'(rs1_r));
      sqx2_r    <= SQ_W'(ax1_r[RS_W-1:0]) * SQ_W'(ax1_r[RS_W-1:0]);
      sqy2_r    <= SQ_W'(ay1_r[RS_W-1:0]) * SQ_W'(ay1_r[RS_W-1:0]);
      rs_sq2_r  <= SQ_W'(rs1_r) * SQ_W'(rs1_r);
      min_sq2_r <= MIN2_W'(min_distance_r) * MIN2_W'(min_distance_r);
      side2_r.contact <= 1'b0;
      side2_r.mode    <= mode1_r;
      side2_r.sx      <= sx1_r;
      side2_r.sy      <= sy1_r;
      side2_r.rs      <= rs1_r;
      side2_r.ax      <= ax1_r[RS_W-1:0];
      side2_r.ay      <= ay1_r[RS_W-1:0];
    end
  end

  // Stage 3: squared distance and contact decision
  logic [D2_W-1:0] d2_s3;
  side_t           side_s3;

  always_comb begin
    d2_s3   = D2_W'(sqx2_r) + D2_W'(sqy2_r);
    side_s3 = side2_r;
    side_s3.contact = near2_r && (d2_s3 < D2_W'(rs_sq2_r)) && (d2_s3 > D2_W'(min_sq2_r));
  end

  logic            v3_r;
  logic [SQ_W-1:0] d2_3_r;
  side_t           side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_3_r  <= d2_s3[SQ_W-1:0];
      side3_r <= side_s3;
    end
  end

  // Distance root, with the side data riding a matching delay line
  logic [ROOT_W-1:0] d_root;

  cpcr_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({d2_3_r, {SQRT_SHIFT{1'b0}}}),
    .root     (d_root)
  );

  logic  vs_r   [SQRT_STAGES];
  side_t sides_r[SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        vs_r[k] <= 1'b0;
      end
    end else if (en) begin
      vs_r[0] <= v3_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        vs_r[k] <= vs_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sides_r[0] <= side3_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sides_r[k] <= sides_r[k-1];
      end
    end
  end

  // Stage 4: overlap = radius sum (Q.8) minus distance
  logic              v4_r;
  logic [ROOT_W-1:0] overlap4_r, d4_r;
  side_t             side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= vs_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap4_r <= {sides_r[SQRT_STAGES-1].rs, 8'h00} - d_root;
      d4_r       <= d_root;
      side4_r    <= sides_r[SQRT_STAGES-1];
    end
  end

  // Stage 5: push = overlap * keep_fraction
  logic              v5_r;
  logic [PROD_W-1:0] prod_s5;
  logic [PUSH_W-1:0] push5_r;
  logic [ROOT_W-1:0] d5_r;
  side_t             side5_r;

  assign prod_s5 = PROD_W'(overlap4_r) * PROD_W'(keep_fraction_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      push5_r <= prod_s5[FRAC_SH +: PUSH_W];
      d5_r    <= d4_r;
      side5_r <= side4_r;
    end
  end

  // Stage 6: numerators push*|c|; divisor d, or 2d when both circles move
  logic                 v6_r;
  logic [NUM_W-1:0]     numx6_r, numy6_r;
  logic [DIVISOR_W-1:0] den6_r;
  side_t                side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numx6_r <= NUM_W'(push5_r) * NUM_W'(side5_r.ax);
      numy6_r <= NUM_W'(push5_r) * NUM_W'(side5_r.ay);
      den6_r  <= (side5_r.mode == MODE_SHARED) ? {d5_r, 1'b0} : {1'b0, d5_r};
      side6_r <= side5_r;
    end
  end

  // Direction scaling dividers, one per axis
  logic [Q_W-1:0] qx, qy;

  cpcr_div u_div_x (
    .clk     (clk),
    .en      (en),
    .num     (numx6_r),
    .divisor (den6_r),
    .quot    (qx)
  );

  cpcr_div u_div_y (
    .clk     (clk),
    .en      (en),
    .num     (numy6_r),
    .divisor (den6_r),
    .quot    (qy)
  );

  logic  vd_r   [DIV_STAGES];
  side_t sided_r[DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= v6_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r[0] <= side6_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        sided_r[k] <= sided_r[k-1];
      end
    end
  end

  // Output stage: apply signs, pick the moving circle, saturate
  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[COORD_WIDTH-1:0];
  endfunction

  side_t                   side_o;
  logic signed [SAT_W-1:0] vx, vy;
  logic [COORD_WIDTH-1:0]  fdx_nxt, fdy_nxt, sdx_nxt, sdy_nxt;

  always_comb begin
    side_o  = sided_r[DIV_STAGES-1];
    vx      = side_o.sx ? -SAT_W'(qx) : SAT_W'(qx);
    vy      = side_o.sy ? -SAT_W'(qy) : SAT_W'(qy);
    fdx_nxt = '0;
    fdy_nxt = '0;
    sdx_nxt = '0;
    sdy_nxt = '0;
    if (side_o.contact) begin
      case (side_o.mode)
        MODE_FIRST_FIXED: begin
          sdx_nxt = sat(vx);
          sdy_nxt = sat(vy);
        end
        MODE_SECOND_FIXED: begin
          fdx_nxt = sat(-vx);
          fdy_nxt = sat(-vy);
        end
        default: begin
          sdx_nxt = sat(vx);
          sdy_nxt = sat(vy);
          fdx_nxt = sat(-vx);
          fdy_nxt = sat(-vy);
        end
      endcase
    end
  end

  logic                   out_valid_r, out_contact_r;
  logic [COORD_WIDTH-1:0] fdx_r, fdy_r, sdx_r, sdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_contact_r <= side_o.contact;
      fdx_r         <= fdx_nxt;
      fdy_r         <= fdy_nxt;
      sdx_r         <= sdx_nxt;
      sdy_r         <= sdy_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_contact   = out_contact_r;
  assign out_first_dx  = fdx_r;
  assign out_first_dy  = fdy_r;
  assign out_second_dx = sdx_r;
  assign out_second_dy = sdy_r;

endmodule
